/* src/mafilt_pkg.sv */
// Shared widths, constants and register map of the moving average filter.
`timescale 1ns / 1ps
`default_nettype none
package mafilt_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W   = 16;
  // A sum of MAX_WINDOW samples needs IDX_W extra bits plus a sign guard.
  localparam int SUM_W      = SAMPLE_W + IDX_W + 1;
  localparam int MAG_W      = SUM_W - 1;
  localparam int CNT_W      = $clog2(MAG_W);

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Register index 0 is the window size; any other word index is unused.
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Ring entries that were never written read as 25 degrees in Q8.8.
  localparam logic signed [SAMPLE_W-1:0] FILL_VALUE = 16'sd6400;

endpackage
`default_nettype wire

/* src/mafilt_div.sv */
// Bit-serial signed divider: sum divided by window size, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module mafilt_div
  import mafilt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [WIN_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIX  = 3'b100
  } div_state_t;

  div_state_t         state;
  logic [MAG_W-1:0]   shreg;
  logic [WIN_W-1:0]   rem;
  logic [WIN_W-1:0]   dsor;
  logic [CNT_W-1:0]   cnt;
  logic               neg;

  logic [SUM_W-1:0]   mag_full;
  logic [WIN_W-1:0]   rem_sh;
  logic               fits;

  // The magnitude of the sum fits in MAG_W bits, the most negative sum included.
  assign mag_full = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign rem_sh   = {rem[WIN_W-2:0], shreg[MAG_W-1]};
  assign fits     = (rem_sh >= dsor);
  assign done     = (state == DV_FIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      case (state)
        DV_IDLE: begin
          if (start) begin
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (cnt == '0) begin
            state <= DV_FIX;
          end
        end
        DV_FIX: begin
          state <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          shreg <= mag_full[MAG_W-1:0];
          neg   <= dividend[SUM_W-1];
          dsor  <= divisor;
          rem   <= '0;
          cnt   <= CNT_W'(MAG_W - 1);
        end
      end
      DV_RUN: begin
        // One quotient bit per cycle enters at the bottom as a dividend bit leaves the top.
        rem   <= fits ? WIN_W'(rem_sh - dsor) : rem_sh;
        shreg <= {shreg[MAG_W-2:0], fits};
        cnt   <= cnt - 1'b1;
      end
      DV_FIX: begin
        quotient <= neg ? -$signed(shreg[SAMPLE_W-1:0]) : $signed(shreg[SAMPLE_W-1:0]);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/moving_average_filter_core.sv */
// Top level of the moving average filter: ring buffer, running sum and result register.
//
// Usage. Samples enter on the sample channel (sample_valid / sample_ready, one
// signed Q8.8 temperature per beat) and means leave on the average channel
// (average_valid / average_ready). The window size is written over the APB port
// at byte address 0; a write of a new size refills the ring with 25 degrees and
// restarts the write position at entry 0. Writing the size already held does
// nothing. While the window size is 0, samples are accepted and dropped.
// An accepted sample steps through the read, subtract, add, start, divide and
// output states, waiting in output for a free output register, before a new
// sample is taken. The serial divider gives one quotient bit per cycle over the
// 22-bit magnitude of the running sum. The ring is a 64-entry memory with one
// registered read port; per-entry valid bits make unwritten entries read as
// 25 degrees, so no clearing pass is needed after reset or a size change.
// Reset sets the window size to 0 and empties the ring and the output register.
// When the receiver stalls, the finished average waits in the output register
// while the next sample is already accepted; the block then holds its next
// result until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module moving_average_filter_core
  import mafilt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  // Sample input channel
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  // Average output channel
  output logic                       average_valid,
  input  logic                       average_ready,
  output logic signed [SAMPLE_W-1:0] average
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_ADD  = 7'b0001000,
    ST_GO   = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t                      state;
  logic [WIN_W-1:0]            window_size;
  logic [IDX_W-1:0]            write_index;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic signed [SAMPLE_W-1:0]  ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]       valid;
  logic signed [SAMPLE_W-1:0]  rd_data;
  logic                        rd_valid;

  logic                        in_beat;
  logic                        out_free;
  logic                        cfg_wr;
  logic [WIN_W-1:0]            win_raw;
  logic [WIN_W-1:0]            win_sat;
  logic                        win_change;
  logic [SUM_W-1:0]            fill_sum;
  logic signed [SAMPLE_W-1:0]  old_val;
  logic [WIN_W-1:0]            index_inc;
  logic [IDX_W-1:0]            write_index_next;
  logic                        div_done;
  logic signed [SAMPLE_W-1:0]  div_quotient;

  assign pready       = 1'b1;
  assign sample_ready = (state == ST_IDLE);
  assign in_beat      = sample_valid && sample_ready;
  assign out_free     = !average_valid || average_ready;

  // Configuration decode: the written value is cut to 7 bits and saturated.
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
  assign win_raw    = pwdata[WIN_W-1:0];
  assign win_sat    = (win_raw > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_raw;
  assign win_change = cfg_wr && (win_sat != window_size);

  // After a refill every active entry holds 6400 = (16 + 8 + 1) * 256.
  assign fill_sum = (SUM_W'(win_sat) << 12) + (SUM_W'(win_sat) << 11)
                  + (SUM_W'(win_sat) << 8);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) begin
      prdata = APB_DW'(window_size);
    end
  end

  // The entry leaving the window reads as 25 degrees until it is first written.
  assign old_val = rd_valid ? rd_data : FILL_VALUE;

  assign index_inc        = WIN_W'(write_index) + 1'b1;
  assign write_index_next = (index_inc >= window_size) ? '0 : index_inc[IDX_W-1:0];

  // Sequencer: read the leaving entry, retire it from the running sum, add the
  // new sample, then divide serially and hand the mean to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat && (window_size != '0)) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_SUB;
        ST_SUB:  state <= ST_ADD;
        ST_ADD:  state <= ST_GO;
        ST_GO:   state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Control registers: window size, write position, running sum and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= '0;
      write_index <= '0;
      sum         <= '0;
      valid       <= '0;
    end else if (win_change) begin
      window_size <= win_sat;
      write_index <= '0;
      sum         <= $signed(fill_sum);
      valid       <= '0;
    end else begin
      case (state)
        ST_SUB: begin
          sum                <= sum - SUM_W'(old_val);
          valid[write_index] <= 1'b1;
          write_index        <= write_index_next;
        end
        ST_ADD: begin
          sum <= sum + SUM_W'(sample_q);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      sample_q <= sample;
    end
  end

  // Ring memory with one registered read port; the write lands on the entry just read.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data  <= ring[write_index];
      rd_valid <= valid[write_index];
    end
    if (state == ST_SUB) begin
      ring[write_index] <= sample_q;
    end
  end

  mafilt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_GO),
    .dividend (sum),
    .divisor  (window_size),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Output register: loading a new mean takes priority over the beat leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      average_valid <= 1'b1;
    end else if (average_ready) begin
      average_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      average <= div_quotient;
    end
  end

endmodule
`default_nettype wire

/* tb/tb_moving_average_filter_core.sv */
// Self-checking testbench for the moving average filter core.
`timescale 1ns / 1ps
module tb_moving_average_filter_core;
  import mafilt_pkg::*;

  // Cycles to let pass after the last mean before touching the window register.
  // This leaves a comfortable margin after the last owed mean has arrived.
  localparam int SETTLE_CYCLES = 64;
  // Length of the long receiver stall that backs the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Beats that count toward each random phase: only beats that yield a mean count.
  localparam int BEATS_PER_PHASE = 250;
  // Upper bound on the run length in cycles; reaching it ends the run as failed.
  localparam int CYCLE_LIMIT = 600000;

  // The window size register and the unused word one address above it.
  localparam logic [1:0] REG_WINDOW = 2'(REG_WINDOW_SIZE);
  localparam logic [1:0] REG_UNUSED = 2'd1;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  // One row of the directed table. A write row carries a register index and data.
  // A beat row carries a sample and, where the answer is obvious, the mean it
  // should produce; rows without a typed mean are checked against the predictor.
  typedef struct packed {
    row_kind_t                  kind;
    logic [1:0]                 reg_index;
    logic [31:0]                wdata;
    logic signed [SAMPLE_W-1:0] beat;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 28;

  localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // Window is zero after reset: samples are dropped, and so is a write to the
    // unused register.
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd100,    1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd1,     1'b0, 16'sd0},
    '{ROW_WRITE, REG_UNUSED, 32'd5,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd77,     1'b0, 16'sd0},
    // A window of one passes every sample straight through, extremes included.
    '{ROW_WRITE, REG_WINDOW, 32'd1,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd32767,  1'b1, 16'sd32767},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd0,      1'b1, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd1,     1'b1, -16'sd1},
    // New window of two: the ring refills with 25 degrees, so -6401 averages
    // with 6400 to -1/2, which truncates toward zero.
    '{ROW_WRITE, REG_WINDOW, 32'd2,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd6401,  1'b1, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd3,      1'b0, 16'sd0},
    // Rewriting the size already held must leave the ring alone.
    '{ROW_WRITE, REG_WINDOW, 32'd2,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd1,      1'b0, 16'sd0},
    // Only seven data bits are used, and 69 saturates to the full window.
    '{ROW_WRITE, REG_WINDOW, 32'h1C5, 16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd32767,  1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b0, 16'sd0},
    // 127 saturates to the same full window, so nothing changes.
    '{ROW_WRITE, REG_WINDOW, 32'd127, 16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd12345,  1'b0, 16'sd0},
    '{ROW_WRITE, REG_WINDOW, 32'd3,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b0, 16'sd0},
    // Going back to zero disables the output again.
    '{ROW_WRITE, REG_WINDOW, 32'd0,   16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd5,      1'b0, 16'sd0},
    '{ROW_WRITE, REG_WINDOW, 32'd64,  16'sd0,      1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   -16'sd32768, 1'b0, 16'sd0},
    '{ROW_BEAT,  REG_WINDOW, 32'd0,   16'sd32767,  1'b0, 16'sd0}
  };

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       sample_valid;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       average_valid;
  logic                       average_ready;
  logic signed [SAMPLE_W-1:0] average;

  moving_average_filter_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .average_valid (average_valid),
    .average_ready (average_ready),
    .average       (average)
  );

  // Our own copy of the filter state: window size, ring contents and the slot
  // that the next sample overwrites.
  logic [WIN_W-1:0]           window_now;
  logic signed [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
  int unsigned                next_slot;

  // Means still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] pending_means [$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_request;
  logic signed [SAMPLE_W-1:0] owed_mean;

  function automatic void refill_ring_copy();
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ring_copy[i] = FILL_VALUE;
    end
    next_slot = 0;
  endfunction

  // A write to the window register masks to seven bits and saturates at the
  // largest window. Only a real change of size refills the ring.
  function automatic void note_register_write(input logic [1:0] idx, input logic [31:0] data);
    int unsigned w;
    if (idx != REG_WINDOW) begin
      return;
    end
    w = data & 32'h7F;
    if (w > MAX_WINDOW) begin
      w = MAX_WINDOW;
    end
    if (w == window_now) begin
      return;
    end
    window_now = WIN_W'(w);
    refill_ring_copy();
  endfunction

  // Stores the sample in the ring and returns the mean of the active entries.
  // Integer division in SystemVerilog truncates toward zero, as the block must.
  function automatic logic signed [SAMPLE_W-1:0] mean_after_sample(
    input logic signed [SAMPLE_W-1:0] s
  );
    int sum;
    int mean;
    sum = 0;
    if (next_slot >= window_now) begin
      next_slot = 0;
    end
    ring_copy[next_slot] = s;
    for (int i = 0; i < int'(window_now); i++) begin
      sum += int'(ring_copy[i]);
    end
    mean = sum / int'(window_now);
    next_slot++;
    if (next_slot >= window_now) begin
      next_slot = 0;
    end
    return SAMPLE_W'(mean);
  endfunction

  // Setup cycle, then access cycle; the register takes the data at the edge that
  // closes the access cycle with pready high.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    note_register_write(idx, data);
  endtask

  // Offers one sample beat and holds it until accepted. A beat taken while the
  // window is zero is dropped by the block and owes no mean.
  task automatic send_beat(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       typed,
    input logic signed [SAMPLE_W-1:0] want
  );
    logic signed [SAMPLE_W-1:0] mean;
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) begin
      @(posedge clk);
    end
    if (window_now != 0) begin
      mean = mean_after_sample(s);
      pending_means.push_back(typed ? want : mean);
    end
  endtask

  // Drops valid and waits until every owed mean has arrived, then for the extra
  // cycles asked. The task always waits on the clock first, so valid never toggles within a step.
  task automatic wait_for_means(input int settle);
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, so that a hung handshake or a lost mean still ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("moving_average_filter_core test failed");
      $finish;
    end
  end

  // Receiver: checks every mean beat against the oldest owed mean and then
  // decides ready for the next cycle. A hold request from the stimulus turns
  // into a long stall counted down here.
  always @(posedge clk) begin
    if (rst) begin
      average_ready <= 1'b0;
    end else begin
      if (average_valid && average_ready) begin
        if (pending_means.size() == 0) begin
          error_count++;
          $display("%0t: mean beat %0d arrived with none expected", $time, average);
        end else begin
          owed_mean = pending_means.pop_front();
          if (average !== owed_mean) begin
            error_count++;
            $display("%0t: average expected %0d, actual %0d", $time, owed_mean, average);
          end
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        average_ready <= 1'b0;
      end else begin
        average_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    int counted;
    int chunk;
    int pause_at;
    bit hold_done;

    // Every input is known from time zero, and reset starts out asserted.
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sample_valid  = 1'b0;
    sample        = '0;
    average_ready = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    window_now    = '0;
    refill_ring_copy();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, no idling on either side. Register writes wait for the
    // block to go quiet first.
    foreach (DIRECTED_TABLE[i]) begin
      if (DIRECTED_TABLE[i].kind == ROW_WRITE) begin
        wait_for_means(SETTLE_CYCLES);
        apb_write(DIRECTED_TABLE[i].reg_index, DIRECTED_TABLE[i].wdata);
      end else begin
        send_beat(DIRECTED_TABLE[i].beat, DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].want);
      end
    end
    wait_for_means(SETTLE_CYCLES);

    // Random phases: a fast sender with a slow receiver, then the reverse, then
    // both at full rate. Each phase walks through a series of windows, each
    // followed by a chunk of samples long enough to wrap small rings many times.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 84 : 0;
      recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 27 : 0;
      counted = 0;
      while (counted < BEATS_PER_PHASE) begin
        wait_for_means(SETTLE_CYCLES);
        case ($urandom_range(0, 11))
          0:       apb_write(REG_UNUSED, $urandom());
          1:       apb_write(REG_WINDOW, 32'd0);
          2:       apb_write(REG_WINDOW, 32'd1);
          3:       apb_write(REG_WINDOW, 32'(MAX_WINDOW));
          4:       apb_write(REG_WINDOW, $urandom());
          default: apb_write(REG_WINDOW, $urandom_range(1, 12));
        endcase
        chunk    = (window_now == 0) ? 4 : $urandom_range(10, 60);
        pause_at = $urandom_range(0, 2 * chunk);

        // Once, with the receiver otherwise always ready, stall it for a long
        // stretch while samples keep coming, so the block backs up and drops
        // its input ready.
        if (ph == 2 && !hold_done && window_now != 0) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end

        for (int k = 0; k < chunk; k++) begin
          // Now and then the sender stops until every owed mean is back.
          if (k == pause_at) begin
            wait_for_means(0);
          end
          case ($urandom_range(0, 7))
            0:       s = 16'sh7FFF;
            1:       s = 16'sh8000;
            2:       s = FILL_VALUE ^ SAMPLE_W'($urandom_range(0, 255));
            default: s = SAMPLE_W'($urandom());
          endcase
          send_beat(s, 1'b0, '0);
          if (window_now != 0) begin
            counted++;
          end
          if ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
    end

    wait_for_means(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("moving_average_filter_core test passed");
    end else begin
      $display("moving_average_filter_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mafilt_pkg.sv
src/mafilt_div.sv
src/moving_average_filter_core.sv
tb/tb_moving_average_filter_core.sv
